// ===== hw/rtl/ie13v_pkg.sv =====
// ============================================================================
// ie13v_pkg
// Shared types, character codes and small modular helpers for the
// ISBN / EAN-13 check digit validator.
// ============================================================================
package ie13v_pkg;

    // Field widths
    localparam int CHAR_W       = 8;
    localparam int DIGITS       = 13;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int OUT_TDATA_W  = ((BCD_W + 7) / 8) * 8;
    localparam int STATUS_W     = 2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LOW  = 8'h78;

    // Bookland prefix "978" as BCD, and its EAN sum (9 + 7*3 + 8) mod 10
    localparam logic [11:0] PREFIX_978_BCD = 12'h978;
    localparam logic [3:0]  PREFIX_SUM     = 4'd8;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_EAN13     = 2'd0,
        ST_ISBN10    = 2'd1,
        ST_COMPLETED = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    // x mod 10 for x <= 36, by reciprocal multiply (205/2048)
    function automatic logic [3:0] mod10_u6(input logic [5:0] x);
        logic [13:0] p;
        logic [2:0]  q;
        logic [5:0]  r;
        p = 14'(x) * 14'd205;
        q = p[13:11];
        r = x - 6'(q) * 6'd10;
        return r[3:0];
    endfunction

    // x mod 11 for x <= 100, by reciprocal multiply (187/2048)
    function automatic logic [3:0] mod11_u7(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 15'(x) * 15'd187;
        q = p[14:11];
        r = x - 7'(q) * 7'd11;
        return r[3:0];
    endfunction

    // (10 - s) mod 10 for s in 0..9
    function automatic logic [3:0] check10(input logic [3:0] s);
        return (s == 4'd0) ? 4'd0 : 4'd10 - s;
    endfunction

    // (11 - s) mod 11 for s in 0..10
    function automatic logic [3:0] check11(input logic [3:0] s);
        return (s == 4'd0) ? 4'd0 : 4'd11 - s;
    endfunction

endpackage

// ===== hw/rtl/isbn_ean13_validator.sv =====
// ============================================================================
// isbn_ean13_validator
// Streams identifier characters in, gives an EAN-13 status and BCD digits.
// ============================================================================
// One character is taken per cycle with no gaps unless the input side stalls.
// Each character passes once through an input register and the short decode
// and sum-update logic behind it, so a new one can follow in every cycle
// unless stalled. The character marked tlast moves from the input register
// into the result register, which raises m_tvalid. Other characters give no
// result. Hyphens and spaces are skipped; X or x is taken as the tenth
// ISBN-10 digit only. The status on m_tuser is 0 for a valid EAN-13, 1 for an
// ISBN-10 converted to 978-EAN, 2 for twelve digits completed with a check
// digit, 3 for invalid (digits then read as zero). The input side keeps
// accepting while a result waits on m_tready. It stalls only when a second
// last character would need the occupied output register.
module isbn_ean13_validator (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side: tdata = char_code[7:0]; tlast = is_last
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ie13v_pkg::CHAR_W-1:0]       s_tdata,
    input  logic                               s_tlast,
    // master side: tdata = ean_digits_bcd[51:0], zero fill [55:52]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ie13v_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // master side: tuser = status[1:0]
    output logic [ie13v_pkg::STATUS_W-1:0]     m_tuser
);
    import ie13v_pkg::*;

    // Input register
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    // Running state
    logic [BCD_W-1:0]   store_reg,     store_next;
    logic [3:0]         count_reg,     count_next;
    logic               too_many_reg,  too_many_next;
    logic               bad_char_reg,  bad_char_next;
    logic [3:0]         ean_sum_reg,   ean_sum_next;
    logic [3:0]         isbn_sum_reg,  isbn_sum_next;
    logic [3:0]         pre_sum_reg,   pre_sum_next;
    logic               tenth_x_reg,   tenth_x_next;

    // Result register
    logic               out_valid_reg;
    logic [BCD_W-1:0]   bcd_reg,       bcd_next;
    status_t            status_reg,    status_next;

    logic out_free;
    logic advance;
    logic in_xfer;

    // Handshake: the stage moves unless it holds a last char and the
    // output register is still occupied
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    // Character decode and running sum update
    logic       is_digit;
    logic       is_sep;
    logic       is_x;
    logic [3:0] dig;
    logic [3:0] isbn_w;
    logic [5:0] ean_acc;
    logic [6:0] isbn_acc;
    logic [5:0] pre_acc;

    always_comb
    begin
        is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
        is_sep   = (char_reg == CH_HYPHEN) || (char_reg == CH_SPACE);
        is_x     = (char_reg == CH_X_UP) || (char_reg == CH_X_LOW);
        dig      = char_reg[3:0];
        isbn_w   = 4'd10 - count_reg;

        ean_acc  = 6'(ean_sum_reg) + (count_reg[0] ? 6'(dig) * 6'd3 : 6'(dig));
        pre_acc  = 6'(pre_sum_reg) + (count_reg[0] ? 6'(dig) : 6'(dig) * 6'd3);
        isbn_acc = 7'(isbn_sum_reg) + 7'(dig) * 7'(isbn_w);

        store_next    = store_reg;
        count_next    = count_reg;
        too_many_next = too_many_reg;
        bad_char_next = bad_char_reg;
        ean_sum_next  = ean_sum_reg;
        isbn_sum_next = isbn_sum_reg;
        pre_sum_next  = pre_sum_reg;
        tenth_x_next  = tenth_x_reg;

        if (is_digit)
        begin
            if (count_reg >= 4'd13)
            begin
                too_many_next = 1'b1;
            end
            else
            begin
                if (count_reg < 4'd12)
                begin
                    ean_sum_next = mod10_u6(ean_acc);
                end
                if (count_reg < 4'd9)
                begin
                    isbn_sum_next = mod11_u7(isbn_acc);
                    pre_sum_next  = mod10_u6(pre_acc);
                end
                store_next = {store_reg[BCD_W-5:0], dig};
                count_next = count_reg + 4'd1;
            end
        end
        else if (is_sep)
        begin
            // separator: skipped
        end
        else if (is_x && count_reg == 4'd9 && !tenth_x_reg)
        begin
            tenth_x_next = 1'b1;
            store_next   = {store_reg[BCD_W-5:0], 4'd0};
            count_next   = 4'd10;
        end
        else
        begin
            bad_char_next = 1'b1;
        end
    end

    // Final verdict from the updated state
    logic [3:0] ean_chk;
    logic [3:0] isbn_chk;
    logic [3:0] pre_chk;

    always_comb
    begin
        ean_chk     = check10(ean_sum_next);
        isbn_chk    = check11(isbn_sum_next);
        pre_chk     = check10(pre_sum_next);
        status_next = ST_INVALID;
        bcd_next    = '0;

        if (!bad_char_next && !too_many_next)
        begin
            if (count_next == 4'd13 && !tenth_x_next)
            begin
                if (store_next[3:0] == ean_chk)
                begin
                    status_next = ST_EAN13;
                    bcd_next    = store_next;
                end
            end
            else if (count_next == 4'd12 && !tenth_x_next)
            begin
                status_next = ST_COMPLETED;
                bcd_next    = {store_next[BCD_W-5:0], ean_chk};
            end
            else if (count_next == 4'd10)
            begin
                if (tenth_x_next ? (isbn_chk == 4'd10) : (store_next[3:0] == isbn_chk))
                begin
                    status_next = ST_ISBN10;
                    bcd_next    = {PREFIX_978_BCD, store_next[39:4], pre_chk};
                end
            end
        end
    end

    // Running state registers: cleared after each last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg    <= '0;
            count_reg    <= '0;
            too_many_reg <= 1'b0;
            bad_char_reg <= 1'b0;
            ean_sum_reg  <= '0;
            isbn_sum_reg <= '0;
            pre_sum_reg  <= PREFIX_SUM;
            tenth_x_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                store_reg    <= '0;
                count_reg    <= '0;
                too_many_reg <= 1'b0;
                bad_char_reg <= 1'b0;
                ean_sum_reg  <= '0;
                isbn_sum_reg <= '0;
                pre_sum_reg  <= PREFIX_SUM;
                tenth_x_reg  <= 1'b0;
            end
            else
            begin
                store_reg    <= store_next;
                count_reg    <= count_next;
                too_many_reg <= too_many_next;
                bad_char_reg <= bad_char_next;
                ean_sum_reg  <= ean_sum_next;
                isbn_sum_reg <= isbn_sum_next;
                pre_sum_reg  <= pre_sum_next;
                tenth_x_reg  <= tenth_x_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            bcd_reg    <= bcd_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(bcd_reg);
    assign m_tuser  = status_reg;

endmodule

// ===== hw/rtl/ie13v_checker.sv =====
// ============================================================================
// ie13v_checker
// Port-level checks on the validator's result stream.
// ============================================================================
module ie13v_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ie13v_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic [ie13v_pkg::STATUS_W-1:0]     m_tuser
);
    import ie13v_pkg::*;

    // A stalled result transfer keeps its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Invalid identifiers carry no digits
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_INVALID |-> m_tdata == '0)
        else $error("invalid result with nonzero digits");

    // A converted ISBN-10 always starts with the 978 prefix
    a_isbn_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_ISBN10 |-> m_tdata[51:40] == PREFIX_978_BCD)
        else $error("converted ISBN without 978 prefix");

    // Padding above the thirteen digits stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:BCD_W] == '0)
        else $error("tdata padding nonzero");

endmodule

bind isbn_ean13_validator ie13v_checker u_ie13v_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/isbn_ean13_validator_test.sv =====
// ============================================================================
// isbn_ean13_validator_test
// Self-checking testbench for the ISBN / EAN-13 check digit validator.
// Identifiers are streamed in one character per transfer. A predictor in
// the testbench follows every accepted character and queues the status and
// BCD digits due on the last character of each identifier. Every output
// transfer is compared against the oldest queued result. Directed tests
// cover passing, converted, completed and rejected identifiers. Random
// tests mix well-formed identifiers with corrupted ones and noise. Both
// sides idle at random, except in one stretch that runs with no gaps.
// ============================================================================
module isbn_ean13_validator_test;
    import ie13v_pkg::*;

    // Cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT  = 1000;
    // Cycles to wait after the last expected result has arrived
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        status_t      status;
        logic [51:0]  bcd;
    } ean_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [CHAR_W-1:0]       s_tdata = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    // Results still owed by the block, oldest first
    ean_result_t   pending_codes[$];
    // Characters of the identifier being sent
    logic [7:0]    ident_chars[$];

    int  error_count = 0;
    int  chars_sent = 0;
    int  quiet_cycles = 0;
    // Set to run both sides with no idle cycles
    bit  steady = 1'b0;

    // Predictor state for the identifier in flight
    logic [51:0]  bcd_shift;
    int           digits_seen;
    bit           over_length;
    bit           illegal_char;
    int           ean_acc;
    int           isbn_acc;
    int           bookland_acc;
    bit           x_check;

    isbn_ean13_validator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    task automatic clear_identifier();
        bcd_shift    = '0;
        digits_seen  = 0;
        over_length  = 1'b0;
        illegal_char = 1'b0;
        ean_acc      = 0;
        isbn_acc     = 0;
        bookland_acc = int'(PREFIX_SUM);
        x_check      = 1'b0;
    endtask

    // Work out the result owed for the identifier just closed
    task automatic close_identifier();
        ean_result_t  res;
        int           ean_chk;
        int           isbn_chk;
        int           pre_chk;
        bit           ok;
        ean_chk  = (10 - ean_acc) % 10;
        isbn_chk = (11 - isbn_acc) % 11;
        pre_chk  = (10 - bookland_acc) % 10;
        res.status = ST_INVALID;
        res.bcd    = '0;
        if (!illegal_char && !over_length)
        begin
            if (digits_seen == 13 && !x_check)
            begin
                if (int'(bcd_shift[3:0]) == ean_chk)
                begin
                    res.status = ST_EAN13;
                    res.bcd    = bcd_shift;
                end
            end
            else if (digits_seen == 12 && !x_check)
            begin
                res.status = ST_COMPLETED;
                res.bcd    = {bcd_shift[47:0], 4'(ean_chk)};
            end
            else if (digits_seen == 10)
            begin
                ok = x_check ? (isbn_chk == 10) : (int'(bcd_shift[3:0]) == isbn_chk);
                if (ok)
                begin
                    res.status = ST_ISBN10;
                    res.bcd    = {PREFIX_978_BCD, bcd_shift[39:4], 4'(pre_chk)};
                end
            end
        end
        pending_codes.push_back(res);
        clear_identifier();
    endtask

    // Follow one accepted character
    task automatic track_char(input logic [7:0] c, input logic last);
        int  d;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = int'(c - CH_ZERO);
            if (digits_seen >= 13)
            begin
                over_length = 1'b1;
            end
            else
            begin
                if (digits_seen < 12)
                    ean_acc = (ean_acc + d * ((digits_seen % 2) ? 3 : 1)) % 10;
                if (digits_seen < 9)
                begin
                    isbn_acc     = (isbn_acc + d * (10 - digits_seen)) % 11;
                    bookland_acc = (bookland_acc + d * ((digits_seen % 2) ? 1 : 3)) % 10;
                end
                bcd_shift   = {bcd_shift[47:0], 4'(d)};
                digits_seen = digits_seen + 1;
            end
        end
        else if (c == CH_HYPHEN || c == CH_SPACE)
        begin
            // separator: skipped
        end
        else if ((c == CH_X_UP || c == CH_X_LOW) && digits_seen == 9 && !x_check)
        begin
            x_check     = 1'b1;
            bcd_shift   = {bcd_shift[47:0], 4'h0};
            digits_seen = 10;
        end
        else
        begin
            illegal_char = 1'b1;
        end
        if (last)
            close_identifier();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One character transfer, with random idle cycles ahead of it unless steady is set
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent = chars_sent + 1;
        track_char(c, last);
    endtask

    // Send the buffered identifier, tlast on its final character
    task automatic send_ident();
        int  i;
        for (i = 0; i < ident_chars.size(); i++)
            send_char(ident_chars[i], i == ident_chars.size() - 1);
        ident_chars.delete();
    endtask

    task automatic send_text(input string txt);
        int  i;
        for (i = 0; i < txt.len(); i++)
            ident_chars.push_back(txt[i]);
        send_ident();
    endtask

    // Digit, sometimes followed by a hyphen or space
    task automatic add_digit(input int d);
        ident_chars.push_back(CH_ZERO + 8'(d));
        if ($urandom_range(0, 99) < 12)
            ident_chars.push_back($urandom_range(0, 1) ? CH_HYPHEN : CH_SPACE);
    endtask

    // One random identifier: mostly well formed, the rest broken or noise
    task automatic send_random_ident();
        int          kind;
        int          i;
        int          n;
        int          sum;
        int          chk;
        int          digits[13];
        logic [7:0]  c;
        kind = $urandom_range(0, 99);
        for (i = 0; i < 13; i++)
            digits[i] = $urandom_range(0, 9);
        if (kind < 25)
        begin
            // EAN-13, check digit wrong one time in five
            sum = 0;
            for (i = 0; i < 12; i++)
                sum = sum + digits[i] * ((i % 2) ? 3 : 1);
            chk = (10 - sum % 10) % 10;
            if ($urandom_range(0, 4) == 0)
                chk = (chk + $urandom_range(1, 9)) % 10;
            digits[12] = chk;
            for (i = 0; i < 13; i++)
                add_digit(digits[i]);
        end
        else if (kind < 45)
        begin
            // ISBN-10, check value ten written as X or x
            sum = 0;
            for (i = 0; i < 9; i++)
                sum = sum + digits[i] * (10 - i);
            chk = (11 - sum % 11) % 11;
            if ($urandom_range(0, 4) == 0)
                chk = (chk + $urandom_range(1, 10)) % 11;
            for (i = 0; i < 9; i++)
                add_digit(digits[i]);
            if (chk == 10)
                ident_chars.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LOW);
            else
                add_digit(chk);
        end
        else if (kind < 58)
        begin
            // twelve digits, to be completed
            for (i = 0; i < 12; i++)
                add_digit(digits[i]);
        end
        else if (kind < 68)
        begin
            // too long or too short
            n = $urandom_range(0, 1) ? $urandom_range(14, 17) : $urandom_range(1, 11);
            for (i = 0; i < n; i++)
                add_digit($urandom_range(0, 9));
        end
        else if (kind < 80)
        begin
            // well formed apart from one stray byte
            for (i = 0; i < 13; i++)
                add_digit(digits[i]);
            do
                c = 8'($urandom_range(0, 255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_HYPHEN || c == CH_SPACE);
            ident_chars.insert($urandom_range(0, ident_chars.size()), c);
        end
        else
        begin
            // noise from the full byte range or from the legal characters
            n = $urandom_range(1, 16);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(0, 255));
                    1:       c = $urandom_range(0, 1) ? CH_X_UP : CH_X_LOW;
                    2:       c = $urandom_range(0, 1) ? CH_HYPHEN : CH_SPACE;
                    default: c = CH_ZERO + 8'($urandom_range(0, 9));
                endcase
                ident_chars.push_back(c);
            end
        end
        send_ident();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_ean13_pass();
        send_text("9780306406157");
        send_text("978-0-306-40615-7");
        send_text("978 0 306 40615 8");
        send_text("0000000000000");
        send_text("9999999999999");
    endtask

    task automatic test_isbn10_convert();
        send_text("0-306-40615-2");
        send_text("0-8044-2957-X");
        send_text("080442957x");
        send_text("0-306-40615-3");
        send_text("999999999X");
        send_text("0-306-40615-2 ");
    endtask

    task automatic test_twelve_digit_complete();
        send_text("978030640615");
        send_text("999999999999");
    endtask

    task automatic test_malformed();
        send_text("080442957X0");
        send_text("080442957XX");
        send_text("12X4");
        send_text("97803064061570");
        send_text("-");
        send_text("5");
        send_text("978030640615A7");
        // lowest and highest byte values
        ident_chars.push_back(CH_ZERO);
        ident_chars.push_back(8'hFF);
        ident_chars.push_back(8'h00);
        send_ident();
    endtask

    task automatic test_random_traffic(input int char_goal);
        while (chars_sent < char_goal)
            send_random_ident();
    endtask

    task automatic test_streaming_no_gaps(input int char_goal);
        steady = 1'b1;
        while (chars_sent < char_goal)
            send_random_ident();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 31);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        error_count = error_count + 1;
    endtask

    always @(posedge clk)
    begin : check_results
        ean_result_t  want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                report_mismatch("result with none expected", 64'(m_tdata), 64'(m_tuser));
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[51:0] !== want.bcd)
                    report_mismatch("ean digits", 64'(m_tdata[51:0]), 64'(want.bcd));
                if (m_tdata[OUT_TDATA_W-1:52] !== '0)
                    report_mismatch("tdata fill", 64'(m_tdata[OUT_TDATA_W-1:52]), 64'h0);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
                $display("isbn_ean13_validator test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clear_identifier();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ean13_pass();
        test_isbn10_convert();
        test_twelve_digit_complete();
        test_malformed();
        test_random_traffic(900);
        test_streaming_no_gaps(1200);
        test_random_traffic(1600);

        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_codes.size() == 0)
            $display("isbn_ean13_validator test passed");
        else
            $display("isbn_ean13_validator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ie13v_pkg.sv
hw/rtl/isbn_ean13_validator.sv
hw/rtl/ie13v_checker.sv
tb/isbn_ean13_validator_test.sv
